>>> src/mbr_pkg.sv
// Shared types, codes and defaults of the MSB-first bit reader.
package mbr_pkg;

    localparam int DEF_STORE_DEPTH    = 8;
    localparam int DEF_MAX_FIELD_BITS = 32;
    localparam int FIELD_W            = 32;

    localparam logic [1:0] FUNC_START     = 2'd0;
    localparam logic [1:0] FUNC_PUSH      = 2'd1;
    localparam logic [1:0] FUNC_READ_UNS  = 2'd2;
    localparam logic [1:0] FUNC_READ_SGN  = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [5:0] bit_count;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [1:0]         status;
    } out_item_t;

    // Command passed from the front to the back, with the length already clamped.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [5:0] n;
    } cmd_t;

endpackage

>>> src/msb_first_bit_reader_unit.sv
// Start, push and zero-length or failed reads reach the result queue in the cycle the back end takes them.
// A successful read fetches the B bytes the field touches, where B is 1 to 5;
// the back end fetches one byte a cycle from the store's single read port, then aligns and extends.
// Throughput is one command a cycle if the result queue has room; a successful read blocks the back end.
// Asynchronous active-low reset empties both queues, the store count, slots and bit position.
// Store contents are undefined after reset and need no clearing pass.
module msb_first_bit_reader_unit
    import mbr_pkg::*;
#(
    parameter int STORE_DEPTH    = DEF_STORE_DEPTH,
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic                         cmd_empty;
    logic                         cmd_pop;
    cmd_t                         cmd;
    logic                         res_full;
    logic                         res_push;
    out_item_t                    res;
    logic [$bits(out_item_t)-1:0] res_bits;

    mbr_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    mbr_back #(
        .STORE_DEPTH    (STORE_DEPTH),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    mbr_fifo #(
        .WIDTH ($bits(out_item_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = out_item_t'(res_bits);

endmodule

>>> src/mbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mbr_fifo.sv
// Two-entry queue used between the front and the back and on the result side.
module mbr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> src/mbr_front.sv
// Front end: takes input transfers, clamps the field length and queues commands.
module mbr_front
    import mbr_pkg::*;
#(
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_empty,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    localparam logic [5:0] MAX_N = 6'(MAX_FIELD_BITS);

    cmd_t                  cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_out_bits;

    always_comb
    begin
        cmd_in.func      = item.func;
        cmd_in.data_byte = item.data_byte;
        // Lengths above the widest field are clamped; start and push ignore it.
        if (item.func == FUNC_START || item.func == FUNC_PUSH)
        begin
            cmd_in.n = 6'd0;
        end
        else if (item.bit_count > MAX_N)
        begin
            cmd_in.n = MAX_N;
        end
        else
        begin
            cmd_in.n = item.bit_count;
        end
    end

    mbr_fifo #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out_bits),
        .empty (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_out_bits);

endmodule

>>> src/mbr_back.sv
// Back end: owns the byte store and read position, and executes one command at a time.
module mbr_back
    import mbr_pkg::*;
#(
    parameter int STORE_DEPTH    = DEF_STORE_DEPTH,
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);

    localparam int PW        = $clog2(STORE_DEPTH);
    localparam int HW        = $clog2(STORE_DEPTH + 1);
    localparam int AW        = HW + 3;
    localparam int WIN_BYTES = (MAX_FIELD_BITS + 14) / 8;
    localparam int WIN       = WIN_BYTES * 8;
    localparam int CW        = $clog2(WIN_BYTES + 1);
    localparam int SW        = $clog2(WIN + 1) + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FETCH  = 2'd1;
    localparam logic [1:0] S_ALIGN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [PW-1:0]      read_slot_reg;
    logic [PW-1:0]      read_slot_next;
    logic [PW-1:0]      write_slot_reg;
    logic [PW-1:0]      write_slot_next;
    logic [HW-1:0]      held_reg;
    logic [HW-1:0]      held_next;
    logic [2:0]         bitpos_reg;
    logic [2:0]         bitpos_next;
    logic [PW-1:0]      fetch_addr_reg;
    logic [PW-1:0]      fetch_addr_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [CW-1:0]      nbytes_reg;
    logic [CW-1:0]      nbytes_next;
    logic [SW-1:0]      lshift_reg;
    logic [SW-1:0]      lshift_next;
    logic [5:0]         n_reg;
    logic [5:0]         n_next;
    logic               sgn_reg;
    logic               sgn_next;
    logic [WIN-1:0]     raw_reg;
    logic [WIN-1:0]     raw_next;
    logic [WIN-1:0]     aligned_reg;
    logic [WIN-1:0]     aligned_next;

    logic               ram_we;
    logic [PW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;
    logic [AW-1:0]      avail;
    logic [6:0]         total;
    logic [6:0]         nbytes_full;
    logic [3:0]         consumed;
    logic [PW:0]        slot_sum;
    logic [WIN+31:0]    aligned_ext;
    logic [31:0]        top_word;
    logic [5:0]         rshift;
    logic [31:0]        value;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
        logic [PW-1:0] r;
        if (s == PW'(STORE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + PW'(1);
        end
        return r;
    endfunction

    mbr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (cmd.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A partly read byte always counts as held, so the bit position applies unconditionally.
    assign avail       = {held_reg, 3'b000} - AW'(bitpos_reg);
    assign total       = 7'(bitpos_reg) + 7'(cmd.n);
    assign nbytes_full = total + 7'd7;
    assign consumed    = total[6:3];
    assign slot_sum    = (PW + 1)'(read_slot_reg) + (PW + 1)'(consumed);

    // The field sits at the top of the aligned window; shift it down by 32 - n.
    assign aligned_ext = {aligned_reg, 32'd0};
    assign top_word    = aligned_ext[WIN+31 -: 32];
    assign rshift      = 6'd32 - n_reg;
    assign value       = sgn_reg ? 32'($signed(top_word) >>> rshift) : (top_word >> rshift);

    assign ram_raddr   = (state_reg == S_IDLE) ? read_slot_reg : fetch_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        read_slot_next  = read_slot_reg;
        write_slot_next = write_slot_reg;
        held_next       = held_reg;
        bitpos_next     = bitpos_reg;
        fetch_addr_next = fetch_addr_reg;
        cnt_next        = cnt_reg;
        nbytes_next     = nbytes_reg;
        lshift_next     = lshift_reg;
        n_next          = n_reg;
        sgn_next        = sgn_reg;
        raw_next        = raw_reg;
        aligned_next    = aligned_reg;
        ram_we          = 1'b0;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res.field_value = '0;
        res.status      = STAT_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.func)
                        FUNC_START:
                        begin
                            read_slot_next  = '0;
                            write_slot_next = '0;
                            held_next       = '0;
                            bitpos_next     = 3'd0;
                            res_push        = 1'b1;
                        end
                        FUNC_PUSH:
                        begin
                            res_push = 1'b1;
                            if (held_reg == HW'(STORE_DEPTH))
                            begin
                                res.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                write_slot_next = next_slot(write_slot_reg);
                                held_next       = held_reg + HW'(1);
                            end
                        end
                        default:
                        begin
                            if (cmd.n == 6'd0)
                            begin
                                res_push = 1'b1;
                            end
                            else if (AW'(cmd.n) > avail)
                            begin
                                res_push   = 1'b1;
                                res.status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                // The position moves on now; the fetch starts from the old slot.
                                n_next          = cmd.n;
                                sgn_next        = (cmd.func == FUNC_READ_SGN);
                                nbytes_next     = CW'(nbytes_full[6:3]);
                                lshift_next     = SW'(WIN) - SW'({nbytes_full[6:3], 3'b000})
                                                  + SW'(bitpos_reg);
                                cnt_next        = '0;
                                fetch_addr_next = next_slot(read_slot_reg);
                                bitpos_next     = total[2:0];
                                held_next       = held_reg - HW'(consumed);
                                if (slot_sum >= (PW + 1)'(STORE_DEPTH))
                                begin
                                    read_slot_next = PW'(slot_sum - (PW + 1)'(STORE_DEPTH));
                                end
                                else
                                begin
                                    read_slot_next = PW'(slot_sum);
                                end
                                state_next      = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                raw_next        = {raw_reg[WIN-9:0], ram_rdata};
                fetch_addr_next = next_slot(fetch_addr_reg);
                cnt_next        = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == nbytes_reg)
                begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                aligned_next = raw_reg << lshift_reg;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                res_push        = 1'b1;
                res.field_value = value;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            read_slot_reg  <= '0;
            write_slot_reg <= '0;
            held_reg       <= '0;
            bitpos_reg     <= 3'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            read_slot_reg  <= read_slot_next;
            write_slot_reg <= write_slot_next;
            held_reg       <= held_next;
            bitpos_reg     <= bitpos_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fetch_addr_reg <= fetch_addr_next;
        nbytes_reg     <= nbytes_next;
        lshift_reg     <= lshift_next;
        n_reg          <= n_next;
        sgn_reg        <= sgn_next;
        raw_reg        <= raw_next;
        aligned_reg    <= aligned_next;
    end

endmodule
